/* rtl/core/bma_pkg.sv */
// shared types and constants of the buddy allocator
`default_nettype none
package bma_pkg;
   localparam int LEN_W       = 20;
   localparam int NEED_W      = 21;
   localparam int SHIFT_W     = 4;
   localparam int ULV_W       = 3;
   localparam int HDR_W       = 7;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SHIFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USED_LEVELS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_BYTES = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   typedef struct packed {
      logic [SHIFT_W-1:0] block_shift;
      logic [ULV_W-1:0]   used_levels;
      logic [HDR_W-1:0]   header_bytes;
      logic               reinit;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_A_PREP, ST_S_RD, ST_S_CHK, ST_P_RD, ST_P_CHK,
      ST_F_PREP, ST_F_CHK, ST_M_RD, ST_M_CHK
   } state_type;
endpackage
`default_nettype wire

/* rtl/core/bma_ram.sv */
// generic simple dual port ram with registered read
`default_nettype none
module bma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/core/bma_engine.sv */
// allocator sequencer over the free-row and block-info memories
`default_nettype none
module bma_engine #(
   parameter int MAX_ORDER = 7
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bma_pkg::cfg_type                   cfg,
   input  wire logic                               start,
   input  wire logic                               kind,
   input  wire logic [bma_pkg::LEN_W-1:0]          request_length,
   input  wire logic [bma_pkg::LEN_W-1:0]          payload_offset,
   output logic                                    busy,
   output logic                                    rsp_valid,
   output logic [bma_pkg::STATUS_W-1:0]            rsp_status,
   output logic [bma_pkg::LEN_W-1:0]               rsp_result_offset
);
   import bma_pkg::*;

   localparam int BLOCKS = 1 << MAX_ORDER;
   localparam int ROWS   = MAX_ORDER + 1;
   localparam int LVL_W  = $clog2(MAX_ORDER + 1);
   localparam int BW     = MAX_ORDER;
   localparam int AI_W   = 1 + LVL_W;

   state_type state_ff, state_in;
   logic [LVL_W-1:0]  k_ff, k_in, order_ff, order_in;
   logic [BW-1:0]     s_ff, s_in, clr_ff, clr_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [LEN_W-1:0]  off_ff, off_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [LEN_W-1:0]  result_ff, result_in;

   // memory ports
   logic              fr_wr_en, fr_rd_en;
   logic [LVL_W-1:0]  fr_wr_addr, fr_rd_addr;
   logic [BLOCKS-1:0] fr_wr_data, fr_rd_data;
   logic              ai_wr_en, ai_rd_en;
   logic [BW-1:0]     ai_wr_addr, ai_rd_addr;
   logic [AI_W-1:0]   ai_wr_data, ai_rd_data;

   // free map, one row of node bits per level
   bma_ram #(.WIDTH(BLOCKS), .DEPTH(ROWS)) u_free_rows (
      .clock(clock), .wr_en(fr_wr_en), .wr_addr(fr_wr_addr), .wr_data(fr_wr_data),
      .rd_en(fr_rd_en), .rd_addr(fr_rd_addr), .rd_data(fr_rd_data)
   );

   // allocated flag and order per basic block start
   bma_ram #(.WIDTH(AI_W), .DEPTH(BLOCKS)) u_block_info (
      .clock(clock), .wr_en(ai_wr_en), .wr_addr(ai_wr_addr), .wr_data(ai_wr_data),
      .rd_en(ai_rd_en), .rd_addr(ai_rd_addr), .rd_data(ai_rd_data)
   );

   // effective region level
   logic [LVL_W-1:0] lv;
   assign lv = (32'(cfg.used_levels) > MAX_ORDER) ? LVL_W'(MAX_ORDER)
                                                   : LVL_W'(cfg.used_levels);

   // size check and order of an allocate
   logic [31:0]      region;
   logic             no_fit;
   logic [LVL_W-1:0] ord_calc;
   always_comb begin
      region   = 32'd1 << (32'(cfg.block_shift) + 32'(lv));
      no_fit   = 32'(need_ff) > region;
      ord_calc = lv;
      for (int o = MAX_ORDER; o >= 0; o--) begin
         if (o <= 32'(lv) &&
             ((32'd1 << (32'(cfg.block_shift) + o)) >= 32'(need_ff))) begin
            ord_calc = LVL_W'(o);
         end
      end
   end

   // lowest free node of the searched level
   logic [31:0]       span;
   logic [BLOCKS-1:0] avail;
   logic              hit;
   logic [BW-1:0]     hit_idx;
   always_comb begin
      span    = 32'd1 << (lv - k_ff);
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < BLOCKS; i++) begin
         avail[i] = fr_rd_data[i] && (i < span);
      end
      for (int i = BLOCKS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            hit     = 1'b1;
            hit_idx = BW'(i);
         end
      end
   end

   // free offset checks
   logic [LEN_W-1:0] base_a;
   logic [LEN_W-1:0] blk_a;
   logic             free_ok;
   always_comb begin
      base_a  = off_ff - LEN_W'(cfg.header_bytes);
      blk_a   = base_a >> cfg.block_shift;
      free_ok = (off_ff >= LEN_W'(cfg.header_bytes)) &&
                ((base_a & ((LEN_W'(1) << cfg.block_shift) - LEN_W'(1))) == '0) &&
                (32'(blk_a) < (32'd1 << lv));
   end

   // node indexes inside a row
   logic [BW-1:0] s_hit, own_idx, bud_idx, bud_s;
   logic [31:0]   off_calc;
   assign s_hit    = hit_idx << k_ff;
   assign own_idx  = s_ff >> k_ff;
   assign bud_s    = s_ff ^ (BW'(1) << k_ff);
   assign bud_idx  = bud_s >> k_ff;
   assign off_calc = (32'(s_in) << cfg.block_shift) + 32'(cfg.header_bytes);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff      <= k_in;
      order_ff  <= order_in;
      s_ff      <= s_in;
      need_ff   <= need_in;
      off_ff    <= off_in;
      status_ff <= status_in;
      result_ff <= result_in;
   end

   // next state and memory control
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      k_in         = k_ff;
      order_in     = order_ff;
      s_in         = s_ff;
      need_in      = need_ff;
      off_in       = off_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      result_in    = result_ff;
      fr_wr_en     = 1'b0;
      fr_wr_addr   = k_ff;
      fr_wr_data   = fr_rd_data;
      fr_rd_en     = 1'b0;
      fr_rd_addr   = k_ff;
      ai_wr_en     = 1'b0;
      ai_wr_addr   = s_ff;
      ai_wr_data   = '0;
      ai_rd_en     = 1'b0;
      ai_rd_addr   = s_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            fr_wr_en   = 32'(clr_ff) < ROWS;
            fr_wr_addr = LVL_W'(clr_ff);
            fr_wr_data = (LVL_W'(clr_ff) == lv) ? BLOCKS'(1) : '0;
            ai_wr_en   = 1'b1;
            ai_wr_addr = clr_ff;
            ai_wr_data = '0;
            clr_in     = clr_ff + BW'(1);
            if (clr_ff == BW'(BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               need_in  = NEED_W'(request_length) + NEED_W'(cfg.header_bytes);
               off_in   = payload_offset;
               state_in = (kind == KIND_FREE) ? ST_F_PREP : ST_A_PREP;
            end
         end
         ST_A_PREP: begin
            if (no_fit) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_NO_FIT;
               result_in    = '0;
               state_in     = ST_IDLE;
            end else begin
               order_in = ord_calc;
               k_in     = ord_calc;
               state_in = ST_S_RD;
            end
         end
         ST_S_RD: begin
            fr_rd_en = 1'b1;
            state_in = ST_S_CHK;
         end
         ST_S_CHK: begin
            if (hit) begin
               s_in       = s_hit;
               fr_wr_en   = 1'b1;
               fr_wr_data = fr_rd_data & ~(BLOCKS'(1) << hit_idx);
               if (k_ff == order_ff) begin
                  ai_wr_en     = 1'b1;
                  ai_wr_addr   = s_hit;
                  ai_wr_data   = {1'b1, order_ff};
                  rsp_valid_in = 1'b1;
                  status_in    = STATUS_OK;
                  result_in    = off_calc[LEN_W-1:0];
                  state_in     = ST_IDLE;
               end else begin
                  k_in     = k_ff - LVL_W'(1);
                  state_in = ST_P_RD;
               end
            end else if (k_ff == lv) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_NO_FIT;
               result_in    = '0;
               state_in     = ST_IDLE;
            end else begin
               k_in     = k_ff + LVL_W'(1);
               state_in = ST_S_RD;
            end
         end
         ST_P_RD: begin
            fr_rd_en = 1'b1;
            state_in = ST_P_CHK;
         end
         ST_P_CHK: begin
            // split: lower half kept, upper half goes free
            fr_wr_en   = 1'b1;
            fr_wr_data = (fr_rd_data & ~(BLOCKS'(1) << own_idx))
                         | (BLOCKS'(1) << (own_idx + BW'(1)));
            if (k_ff == order_ff) begin
               ai_wr_en     = 1'b1;
               ai_wr_data   = {1'b1, order_ff};
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               result_in    = off_calc[LEN_W-1:0];
               state_in     = ST_IDLE;
            end else begin
               k_in     = k_ff - LVL_W'(1);
               state_in = ST_P_RD;
            end
         end
         ST_F_PREP: begin
            if (free_ok) begin
               s_in       = blk_a[BW-1:0];
               ai_rd_en   = 1'b1;
               ai_rd_addr = blk_a[BW-1:0];
               state_in   = ST_F_CHK;
            end else begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_BAD_FREE;
               result_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_F_CHK: begin
            if (!ai_rd_data[AI_W-1]) begin
               rsp_valid_in = 1'b1;
               status_in    = STATUS_BAD_FREE;
               result_in    = '0;
               state_in     = ST_IDLE;
            end else begin
               ai_wr_en   = 1'b1;
               ai_wr_data = '0;
               k_in       = (ai_rd_data[LVL_W-1:0] > lv) ? lv : ai_rd_data[LVL_W-1:0];
               state_in   = ST_M_RD;
            end
         end
         ST_M_RD: begin
            fr_rd_en = 1'b1;
            state_in = ST_M_CHK;
         end
         ST_M_CHK: begin
            fr_wr_en = 1'b1;
            if (k_ff < lv && fr_rd_data[bud_idx]) begin
               // merge with the free buddy and climb one level
               fr_wr_data = fr_rd_data & ~(BLOCKS'(1) << bud_idx);
               s_in       = (bud_s < s_ff) ? bud_s : s_ff;
               k_in       = k_ff + LVL_W'(1);
               state_in   = ST_M_RD;
            end else begin
               fr_wr_data   = fr_rd_data | (BLOCKS'(1) << own_idx);
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               result_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // a used_levels write restarts the clearing pass
      if (cfg.reinit) begin
         state_in = ST_CLEAR;
         clr_in   = '0;
      end
   end

   // busy also covers the cycle in which a clearing pass is pending
   assign busy              = (state_ff != ST_IDLE) || cfg.reinit;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_result_offset = result_ff;
endmodule
`default_nettype wire

/* rtl/core/buddy_memory_allocator.sv */
// top level of the buddy allocator: configuration registers and sequencer
// Usage:
//   Issue a transaction with start high while busy is low; req_kind selects
//   allocate or free, req_request_length and req_payload_offset carry the
//   operands. Exactly one result follows per transaction: rsp_valid is high
//   for one cycle with rsp_status and rsp_result_offset, and the receiver
//   cannot stall it. The next transaction may start once busy falls.
//   An allocate reads and checks the free row of each level searched and
//   split; a free checks the block info, then the free row of each level
//   merged. The cost is set by the registered free-row read per level visited.
//   Configuration writes go through csr_valid/csr_ready; the user is bound
//   to make them only while the block is idle, and csr_ready stays high, so
//   the block leaves this to the user. After reset and each used_levels
//   write, a clearing pass initializes both memories with busy held high.
`default_nettype none
module buddy_memory_allocator #(
   parameter int MAX_ORDER = 7
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_kind,
   input  wire logic [bma_pkg::LEN_W-1:0]        req_request_length,
   input  wire logic [bma_pkg::LEN_W-1:0]        req_payload_offset,
   output logic                                  rsp_valid,
   output logic [bma_pkg::STATUS_W-1:0]          rsp_status,
   output logic [bma_pkg::LEN_W-1:0]             rsp_result_offset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bma_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bma_pkg::*;

   logic [SHIFT_W-1:0] block_shift_ff;
   logic [ULV_W-1:0]   used_levels_ff;
   logic [HDR_W-1:0]   header_bytes_ff;
   logic               reinit_ff;
   logic               csr_wr;
   cfg_type            cfg;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_shift_ff  <= 4'd7;
         used_levels_ff  <= 3'd7;
         header_bytes_ff <= 7'd16;
         reinit_ff       <= 1'b0;
      end else begin
         reinit_ff <= 1'b0;
         if (csr_wr) begin
            case (csr_index)
               CSR_BLOCK_SHIFT:  block_shift_ff  <= csr_data[SHIFT_W-1:0];
               CSR_USED_LEVELS: begin
                  used_levels_ff <= csr_data[ULV_W-1:0];
                  reinit_ff      <= 1'b1;
               end
               CSR_HEADER_BYTES: header_bytes_ff <= csr_data[HDR_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign cfg.block_shift  = block_shift_ff;
   assign cfg.used_levels  = used_levels_ff;
   assign cfg.header_bytes = header_bytes_ff;
   assign cfg.reinit       = reinit_ff;

   // allocator sequencer
   bma_engine #(.MAX_ORDER(MAX_ORDER)) u_engine (
      .clock(clock), .reset(reset), .cfg(cfg), .start(start), .kind(req_kind),
      .request_length(req_request_length), .payload_offset(req_payload_offset),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_result_offset(rsp_result_offset)
   );
endmodule
`default_nettype wire
